/* hdl/fsrl_pkg.sv */
// ----------------------------------------------------------------------------
// fsrl_pkg
// Types and constants for the flash sector record log manager.
// ----------------------------------------------------------------------------
package fsrl_pkg;

  localparam int SECTOR_BYTES = 4096;

  // offset width inside the sector, record size width and full product width
  localparam int OFS_W  = $clog2(SECTOR_BYTES);
  localparam int SZ_W   = 13;
  localparam int IDX_W  = 12;
  localparam int WIDE_W = 2 * SZ_W;
  localparam int SUM_W  = ((OFS_W > SZ_W) ? OFS_W : SZ_W) + 2;

  localparam logic [SZ_W-1:0] COUNT_MAX = '1;

  // input kinds
  localparam logic [2:0] KIND_MOUNT     = 3'd0;
  localparam logic [2:0] KIND_SLOT      = 3'd1;
  localparam logic [2:0] KIND_WR_BEGIN  = 3'd2;
  localparam logic [2:0] KIND_WR_RESULT = 3'd3;
  localparam logic [2:0] KIND_READ      = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PROBE     = 3'd1;
  localparam logic [2:0] ST_PROGRAM   = 3'd2;
  localparam logic [2:0] ST_BAD       = 3'd3;
  localparam logic [2:0] ST_PROG_ERR  = 3'd4;
  localparam logic [2:0] ST_IDX_BAD   = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_SECTOR_BASE = 2'd0;
  localparam logic [1:0] REG_ITEM_SIZE   = 2'd1;
  localparam logic [1:0] REG_ITEMS       = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LAST  = 2'd1,
    PH_SCAN  = 2'd2,
    PH_WRITE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic             slot_dirty;
    logic             program_ok;
    logic             verify_ok;
    logic [IDX_W-1:0] item_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [31:0]     op_address;
    logic            erase_first;
    logic [31:0]     newest_address;
    logic [SZ_W-1:0] record_count;
    logic            is_full;
    logic            is_empty;
  } out_item_t;

endpackage

/* hdl/flash_sector_record_log_manager_core.sv */
// ----------------------------------------------------------------------------
// flash_sector_record_log_manager_core
// Bookkeeping for fixed-size records appended into one flash sector.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one event word per flash step:
//     mount begin, slot status, write begin, write outcome or read item.
//   out channel (out_valid/out_ready/out_data): exactly one result word per
//     event, carrying the next flash address to probe or program, the
//     status, and a snapshot of newest address, record count, full, empty.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): sector base,
//     item size and items per sector; cfg_ready is always high and writes
//     are expected only while no event is in flight.
// An accepted event word passes through an input register, then one pass
// of update logic (a 13x13 multiplier and a 32-bit add on the mount and
// read paths) into the result register.
// Throughput is one event per cycle while results are taken; a new event
// is taken while the last result waits. When out_ready is low the result
// register holds, the input register fills, and in_ready drops until the
// result is taken.
// Synchronous reset returns the log state to empty and idle and loads the
// register defaults (base 0, item size 64, 64 items per sector).
// ----------------------------------------------------------------------------
module flash_sector_record_log_manager_core
  import fsrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration
  logic [31:0]      base_r;
  logic [SZ_W-1:0]  size_r;
  logic [SZ_W-1:0]  items_r;

  // log state
  logic [OFS_W-1:0]  wo_r, wo_nxt;
  logic [OFS_W-1:0]  start_r, start_nxt;
  logic [WIDE_W-1:0] newest_r, newest_nxt;
  logic [WIDE_W-1:0] scan_r, scan_nxt;
  logic [SZ_W-1:0]   count_r, count_nxt;
  phase_t            phase_r, phase_nxt;

  // pipeline
  logic      in_valid_r;
  in_item_t  in_r;
  logic      out_valid_r;
  out_item_t out_r, out_nxt;
  logic      advance;

  // shared datapath
  logic [SZ_W-1:0]   sz;
  logic [SZ_W-1:0]   last;
  logic [SZ_W-1:0]   mul_a;
  logic [WIDE_W-1:0] prod;
  logic [SUM_W-1:0]  wo_step;
  logic              wo_wrap;
  logic [OFS_W-1:0]  wo_adv;
  logic [WIDE_W:0]   scan_step;
  logic              scan_fit;
  logic              two_fit;
  logic [OFS_W-1:0]  pr_wo;
  logic [SZ_W-1:0]   count_inc;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign sz    = (size_r == '0) ? SZ_W'(1) : size_r;
  assign last  = (items_r == '0) ? '0 : items_r - SZ_W'(1);
  assign mul_a = (in_r.kind == KIND_MOUNT) ? last : SZ_W'(in_r.item_index);
  assign prod  = WIDE_W'(mul_a) * WIDE_W'(sz);

  assign wo_step = SUM_W'(wo_r) + SUM_W'(sz);
  assign wo_wrap = (32'(wo_step) + 32'(sz)) > 32'(SECTOR_BYTES);
  assign wo_adv  = wo_wrap ? '0 : wo_step[OFS_W-1:0];

  assign scan_step = (WIDE_W+1)'(scan_r) + (WIDE_W+1)'(sz);
  assign scan_fit  = (32'(scan_step) + 32'(sz) + 32'(sz)) <= 32'(SECTOR_BYTES);
  assign two_fit   = (32'(sz) + 32'(sz)) <= 32'(SECTOR_BYTES);

  // a program request follows either write begin or a failed verify
  assign pr_wo     = (in_r.kind == KIND_WR_RESULT) ? wo_adv : wo_r;
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + SZ_W'(1);

  always_comb begin
    wo_nxt     = wo_r;
    start_nxt  = start_r;
    newest_nxt = newest_r;
    scan_nxt   = scan_r;
    count_nxt  = count_r;
    phase_nxt  = phase_r;
    out_nxt    = '0;
    out_nxt.status = ST_OK;

    unique case (in_r.kind)
      KIND_MOUNT: begin
        scan_nxt           = prod;
        out_nxt.status     = ST_PROBE;
        out_nxt.op_address = base_r + 32'(prod);
        phase_nxt          = PH_LAST;
      end
      KIND_SLOT: begin
        if (phase_r == PH_LAST) begin
          if (in_r.slot_dirty) begin
            wo_nxt     = '0;
            newest_nxt = scan_r;
            count_nxt  = items_r;
            phase_nxt  = PH_IDLE;
          end else begin
            wo_nxt     = '0;
            newest_nxt = '0;
            count_nxt  = '0;
            scan_nxt   = '0;
            if (two_fit) begin
              out_nxt.status     = ST_PROBE;
              out_nxt.op_address = base_r;
              phase_nxt          = PH_SCAN;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end else if (phase_r == PH_SCAN) begin
          if (in_r.slot_dirty) begin
            count_nxt  = count_inc;
            newest_nxt = scan_r;
            scan_nxt   = scan_step[WIDE_W-1:0];
            if (scan_fit) begin
              out_nxt.status     = ST_PROBE;
              out_nxt.op_address = base_r + 32'(scan_step);
            end else begin
              phase_nxt = PH_IDLE;
            end
          end else begin
            // first clean slot becomes the write point
            wo_nxt    = scan_r[OFS_W-1:0];
            phase_nxt = PH_IDLE;
          end
        end
      end
      KIND_WR_BEGIN: begin
        start_nxt          = wo_r;
        out_nxt.status     = ST_PROGRAM;
        out_nxt.op_address = base_r + 32'(wo_r);
        phase_nxt          = PH_WRITE;
        if (wo_r == '0) begin
          newest_nxt          = '0;
          count_nxt           = '0;
          out_nxt.erase_first = 1'b1;
        end
      end
      KIND_WR_RESULT: begin
        if (phase_r == PH_WRITE) begin
          if (!in_r.program_ok) begin
            out_nxt.status = ST_PROG_ERR;
            phase_nxt      = PH_IDLE;
          end else begin
            count_nxt  = count_inc;
            newest_nxt = WIDE_W'(wo_r);
            wo_nxt     = wo_adv;
            if (in_r.verify_ok) begin
              phase_nxt = PH_IDLE;
            end else if (start_r == wo_adv) begin
              out_nxt.status = ST_BAD;
              phase_nxt      = PH_IDLE;
            end else begin
              // retry at the next slot, erasing on wrap to zero
              out_nxt.status     = ST_PROGRAM;
              out_nxt.op_address = base_r + 32'(pr_wo);
              if (pr_wo == '0) begin
                newest_nxt          = '0;
                count_nxt           = '0;
                out_nxt.erase_first = 1'b1;
              end
            end
          end
        end
      end
      KIND_READ: begin
        if (SZ_W'(in_r.item_index) >= count_r) begin
          out_nxt.status = ST_IDX_BAD;
        end else begin
          out_nxt.op_address = base_r + 32'(prod);
        end
      end
      default: begin
      end
    endcase

    out_nxt.newest_address = base_r + 32'(newest_nxt);
    out_nxt.record_count   = count_nxt;
    out_nxt.is_full        = (count_nxt == items_r);
    out_nxt.is_empty       = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      size_r  <= SZ_W'(64);
      items_r <= SZ_W'(64);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SECTOR_BASE: base_r  <= cfg_data;
        REG_ITEM_SIZE:   size_r  <= cfg_data[SZ_W-1:0];
        REG_ITEMS:       items_r <= cfg_data[SZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wo_r     <= '0;
      start_r  <= '0;
      newest_r <= '0;
      scan_r   <= '0;
      count_r  <= '0;
      phase_r  <= PH_IDLE;
    end else if (advance) begin
      wo_r     <= wo_nxt;
      start_r  <= start_nxt;
      newest_r <= newest_nxt;
      scan_r   <= scan_nxt;
      count_r  <= count_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* tb/fsrl_log_checker.sv */
// ----------------------------------------------------------------------------
// fsrl_log_checker
// Watches the event, result and register channels of the record log manager,
// keeps its own copy of the log bookkeeping, and checks every result word
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module fsrl_log_checker
  import fsrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]     base_addr;
  logic [SZ_W-1:0] slot_size;
  logic [SZ_W-1:0] slots_total;

  // offsets are kept at 32 bits, the last-slot probe can run past the sector
  logic [31:0] wr_ofs;
  logic [31:0] newest_ofs;
  logic [31:0] rec_count;
  logic [31:0] scan_ofs;
  logic [31:0] start_ofs;
  phase_t      phase;

  out_item_t expected_results[$];

  function automatic void issue_program(output logic [2:0] st, output logic [31:0] addr,
                                        output logic er);
    er = (wr_ofs == 0);
    if (er) begin
      wr_ofs     = 0;
      newest_ofs = 0;
      rec_count  = 0;
    end
    st    = ST_PROGRAM;
    addr  = base_addr + wr_ofs;
    phase = PH_WRITE;
  endfunction

  function automatic out_item_t next_log_result(input in_item_t ev);
    out_item_t   r;
    logic [31:0] sz;
    logic [31:0] last;
    logic [2:0]  st;
    logic [31:0] addr;
    logic        er;
    sz   = (slot_size == 0) ? 32'd1 : 32'(slot_size);
    st   = ST_OK;
    addr = '0;
    er   = 1'b0;
    case (ev.kind)
      KIND_MOUNT: begin
        last     = (slots_total == 0) ? 32'd0 : 32'(slots_total) - 1;
        scan_ofs = last * sz;
        st       = ST_PROBE;
        addr     = base_addr + scan_ofs;
        phase    = PH_LAST;
      end
      KIND_SLOT: begin
        if (phase == PH_LAST) begin
          if (ev.slot_dirty) begin
            // last slot used: sector full
            wr_ofs     = 0;
            newest_ofs = scan_ofs;
            rec_count  = 32'(slots_total);
            phase      = PH_IDLE;
          end else begin
            wr_ofs     = 0;
            newest_ofs = 0;
            rec_count  = 0;
            scan_ofs   = 0;
            if (2 * sz <= SECTOR_BYTES) begin
              st    = ST_PROBE;
              addr  = base_addr;
              phase = PH_SCAN;
            end else begin
              phase = PH_IDLE;
            end
          end
        end else if (phase == PH_SCAN) begin
          if (ev.slot_dirty) begin
            if (rec_count < COUNT_MAX) rec_count++;
            newest_ofs = scan_ofs;
            scan_ofs   = scan_ofs + sz;
            // the scan stops short of the last slot
            if (scan_ofs + 2 * sz <= SECTOR_BYTES) begin
              st   = ST_PROBE;
              addr = base_addr + scan_ofs;
            end else begin
              phase = PH_IDLE;
            end
          end else begin
            wr_ofs = scan_ofs;
            phase  = PH_IDLE;
          end
        end
      end
      KIND_WR_BEGIN: begin
        start_ofs = wr_ofs;
        issue_program(st, addr, er);
      end
      KIND_WR_RESULT: begin
        if (phase == PH_WRITE) begin
          if (!ev.program_ok) begin
            st    = ST_PROG_ERR;
            phase = PH_IDLE;
          end else begin
            if (rec_count < COUNT_MAX) rec_count++;
            newest_ofs = wr_ofs;
            wr_ofs     = wr_ofs + sz;
            if (wr_ofs + sz > SECTOR_BYTES) wr_ofs = 0;
            if (ev.verify_ok) begin
              phase = PH_IDLE;
            end else if (start_ofs == wr_ofs) begin
              // retried all the way round
              st    = ST_BAD;
              phase = PH_IDLE;
            end else begin
              issue_program(st, addr, er);
            end
          end
        end
      end
      KIND_READ: begin
        if (32'(ev.item_index) >= rec_count) st = ST_IDX_BAD;
        else addr = base_addr + 32'(ev.item_index) * sz;
      end
      default: ;
    endcase
    r.status         = st;
    r.op_address     = addr;
    r.erase_first    = er;
    r.newest_address = base_addr + newest_ofs;
    r.record_count   = rec_count[SZ_W-1:0];
    r.is_full        = (rec_count == 32'(slots_total));
    r.is_empty       = (rec_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      base_addr   = '0;
      slot_size   = 13'd64;
      slots_total = 13'd64;
      wr_ofs      = '0;
      newest_ofs  = '0;
      rec_count   = '0;
      scan_ofs    = '0;
      start_ofs   = '0;
      phase       = PH_IDLE;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SECTOR_BASE: base_addr   = cfg_data;
          REG_ITEM_SIZE:   slot_size   = cfg_data[SZ_W-1:0];
          REG_ITEMS:       slots_total = cfg_data[SZ_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: result word with none expected", $time);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status || out_data.op_address !== want.op_address ||
              out_data.erase_first !== want.erase_first ||
              out_data.newest_address !== want.newest_address ||
              out_data.record_count !== want.record_count ||
              out_data.is_full !== want.is_full || out_data.is_empty !== want.is_empty) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch", $time);
              $display("  expected st %0d addr %h erase %0b newest %h count %0d full %0b empty %0b",
                       want.status, want.op_address, want.erase_first, want.newest_address,
                       want.record_count, want.is_full, want.is_empty);
              $display("  actual   st %0d addr %h erase %0b newest %h count %0d full %0b empty %0b",
                       out_data.status, out_data.op_address, out_data.erase_first,
                       out_data.newest_address, out_data.record_count, out_data.is_full,
                       out_data.is_empty);
            end
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(next_log_result(in_data));
    end
    pending = expected_results.size();
  end

endmodule

/* tb/tb_flash_sector_record_log_manager_core.sv */
// ----------------------------------------------------------------------------
// tb_flash_sector_record_log_manager_core
// Drives mount, write and read event words into the record log manager
// under several sector settings and changing back-pressure; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_flash_sector_record_log_manager_core;
  timeunit 1ns;
  timeprecision 1ps;
  import fsrl_pkg::*;

  localparam int N_SETTINGS        = 8;
  localparam int WORDS_PER_SETTING = 225;
  localparam int DRAIN_LIMIT       = 200000;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_data   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        in_ready;
  logic        out_valid;
  logic        cfg_ready;
  out_item_t   out_data;

  int fail_count;
  int pending;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int n_sent          = 0;
  int n_results       = 0;
  int n_holds         = 0;
  int n_setting_words = 0;

  logic [31:0] set_base  [N_SETTINGS];
  logic [31:0] set_size  [N_SETTINGS];
  logic [31:0] set_slots [N_SETTINGS];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  flash_sector_record_log_manager_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fsrl_log_checker log_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic bit roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic rbit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [IDX_W-1:0] ridx();
    return IDX_W'($urandom_range(4095));
  endfunction

  task automatic send_word(input in_item_t w);
    while (roll(send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    n_setting_words++;
  endtask

  task automatic send_ev(input logic [2:0] k, input logic d, input logic p, input logic v,
                         input logic [IDX_W-1:0] idx);
    in_item_t w;
    w.kind       = k;
    w.slot_dirty = d;
    w.program_ok = p;
    w.verify_ok  = v;
    w.item_index = idx;
    send_word(w);
  endtask

  // wait until every word sent has its result back and the block is quiet
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic run_directed();
    int k;
    send_ev(KIND_READ, 1'b0, 1'b0, 1'b0, '0);      // empty log
    send_ev(KIND_READ, 1'b1, 1'b1, 1'b1, '1);
    send_ev(KIND_SLOT, 1'b1, 1'b1, 1'b1, '1);      // no mount running
    send_ev(KIND_WR_RESULT, 1'b0, 1'b1, 1'b1, '0); // no write running
    for (k = KIND_READ + 1; k < 2 ** 3; k++) send_ev(k[2:0], 1'b1, 1'b1, 1'b1, '1);
    send_ev(KIND_MOUNT, 1'b0, 1'b0, 1'b0, '0);
    send_ev(KIND_SLOT, 1'b0, 1'b0, 1'b0, '0);
    repeat (3) send_ev(KIND_SLOT, 1'b1, 1'b0, 1'b0, '0);
    send_ev(KIND_SLOT, 1'b0, 1'b0, 1'b0, '0);
    send_ev(KIND_WR_BEGIN, 1'b0, 1'b0, 1'b0, '0);
    send_ev(KIND_WR_RESULT, 1'b0, 1'b0, 1'b1, '0); // program error
    send_ev(KIND_WR_BEGIN, 1'b0, 1'b0, 1'b0, '0);
    send_ev(KIND_WR_RESULT, 1'b0, 1'b1, 1'b1, '0);
    send_ev(KIND_WR_BEGIN, 1'b0, 1'b0, 1'b0, '0);
    send_ev(KIND_WR_RESULT, 1'b0, 1'b1, 1'b0, '0); // verify fail, retry next slot
    send_ev(KIND_WR_RESULT, 1'b0, 1'b1, 1'b1, '0);
    send_ev(KIND_READ, 1'b0, 1'b0, 1'b0, 12'd5);
    send_ev(KIND_READ, 1'b0, 1'b0, 1'b0, 12'd6);
    // begins that cut into running operations
    send_ev(KIND_MOUNT, 1'b0, 1'b0, 1'b0, '0);
    send_ev(KIND_WR_BEGIN, 1'b0, 1'b0, 1'b0, '0);
    send_ev(KIND_MOUNT, 1'b0, 1'b0, 1'b0, '0);
    send_ev(KIND_SLOT, 1'b1, 1'b0, 1'b0, '0);      // full sector
    send_ev(KIND_READ, 1'b0, 1'b0, 1'b0, 12'd63);
    send_ev(KIND_WR_BEGIN, 1'b0, 1'b0, 1'b0, '0);  // erase first
    send_ev(KIND_WR_RESULT, 1'b0, 1'b1, 1'b1, '0);
  endtask

  // mostly well-formed mount and write sequences, some reads and raw noise
  task automatic random_burst();
    int               n;
    int               pick;
    logic [IDX_W-1:0] idx;
    logic [31:0]      raw;
    pick = $urandom_range(99);
    if (pick < 20) begin
      send_ev(KIND_MOUNT, rbit(), rbit(), rbit(), ridx());
      if (roll(30)) begin
        send_ev(KIND_SLOT, 1'b1, rbit(), rbit(), ridx());
      end else begin
        send_ev(KIND_SLOT, 1'b0, rbit(), rbit(), ridx());
        n = $urandom_range(10);
        repeat (n) send_ev(KIND_SLOT, roll(85), rbit(), rbit(), ridx());
        if (roll(70)) send_ev(KIND_SLOT, 1'b0, rbit(), rbit(), ridx());
      end
    end else if (pick < 65) begin
      send_ev(KIND_WR_BEGIN, rbit(), rbit(), rbit(), ridx());
      n = $urandom_range(1, 4);
      repeat (n) send_ev(KIND_WR_RESULT, rbit(), roll(90), roll(55), ridx());
    end else if (pick < 85) begin
      idx = roll(50) ? IDX_W'($urandom_range(80)) : ridx();
      send_ev(KIND_READ, rbit(), rbit(), rbit(), idx);
    end else begin
      raw = $urandom;
      send_word(in_item_t'(raw[$bits(in_item_t)-1:0]));
    end
  endtask

  // result side: random stalls plus a few long hold-offs
  initial begin
    int hold_left;
    int next_hold_at;
    hold_left    = 0;
    next_hold_at = 300;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) n_results++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (n_results >= next_hold_at) begin
        hold_left    = 80;
        next_hold_at = next_hold_at + 700;
        n_holds++;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !roll(recv_idle_pct);
      end
    end
  end

  initial begin
    int s;
    set_base[1]  = 32'hFFFF_FFFF; set_size[1] = 32'd0;         set_slots[1] = 32'd0;
    set_base[2]  = $urandom;      set_size[2] = 32'd256;       set_slots[2] = 32'd16;
    set_base[3]  = 32'd0;         set_size[3] = 32'd4096;      set_slots[3] = 32'd1;
    set_base[4]  = $urandom;      set_size[4] = 32'hFFFF_FFFF; set_slots[4] = 32'hFFFF_FFFF;
    set_base[5]  = 32'h1234_5678; set_size[5] = 32'd1000;      set_slots[5] = 32'd4;
    set_base[6]  = $urandom;      set_size[6] = 32'd1;         set_slots[6] = 32'd4096;
    set_base[7]  = 32'h0000_1000; set_size[7] = 32'd128;       set_slots[7] = 32'd32;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (s = 0; s < N_SETTINGS; s++) begin
      send_idle_pct = (s < 3) ? 17 : (s < 6) ? 80 : 0;
      recv_idle_pct = (s < 3) ? 80 : (s < 6) ? 17 : 0;
      if (s == 0) begin
        run_directed();
      end else begin
        drain_results();
        write_reg(REG_SECTOR_BASE, set_base[s]);
        write_reg(REG_ITEM_SIZE, set_size[s]);
        write_reg(REG_ITEMS, set_slots[s]);
        if (s == N_SETTINGS - 1) write_reg(REG_SPARE, $urandom);
        cfg_valid <= 1'b0;
      end
      n_setting_words = 0;
      while (n_setting_words < WORDS_PER_SETTING) random_burst();
    end
    drain_results();
    repeat (10) @(posedge clk);
    $display("%0d event words over %0d sector settings, %0d results, %0d long output stalls",
             n_sent, N_SETTINGS, n_results, n_holds);
    $display("mismatches %0d, results still owed %0d", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/fsrl_pkg.sv
hdl/flash_sector_record_log_manager_core.sv
tb/fsrl_log_checker.sv
tb/tb_flash_sector_record_log_manager_core.sv
